### rtl/mfrf_pkg.sv
// ----------------------------------------------------------------------------
// mfrf_pkg
// Shared types and constants of the masked five-tuple rule filter.
// ----------------------------------------------------------------------------
package mfrf_pkg;

	localparam int IN_W  = 112;
	localparam int OUT_W = 24;
	localparam int IDX_W = 7;

	localparam logic [2:0] OP_CLASSIFY  = 3'd0;
	localparam logic [2:0] OP_ADD       = 3'd1;
	localparam logic [2:0] OP_CLEAR     = 3'd2;
	localparam logic [2:0] OP_SET_BLACK = 3'd3;
	localparam logic [2:0] OP_SET_WHITE = 3'd4;

	localparam int SEL_PROTO = 0;
	localparam int SEL_SRC   = 1;
	localparam int SEL_DST   = 2;
	localparam int SEL_SPORT = 3;
	localparam int SEL_DPORT = 4;

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	typedef struct packed {
		logic [4:0]  mask;
		logic [7:0]  proto;
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] sport;
		logic [15:0] dport;
	} rule_t;

	typedef struct packed {
		logic        tcp;
		logic [7:0]  proto;
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] sport;
		logic [15:0] dport;
	} pkt_t;

	typedef struct packed {
		logic             active;
		logic             found;
		logic [IDX_W-1:0] idx;
	} scan_t;

endpackage

### rtl/mfrf_cell.sv
// ----------------------------------------------------------------------------
// mfrf_cell
// One rule slot of the chain: holds a rule, tests the broadcast packet when
// the scan token passes and hands the first-match result to the next cell.
// ----------------------------------------------------------------------------
module mfrf_cell #(
	parameter int CELL_IDX = 0,
	parameter int CNT_W    = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mfrf_pkg::pkt_t       pkt,
	input  logic                 wr_en,
	input  mfrf_pkg::rule_t      wr_rule,
	input  logic [CNT_W-1:0]     count,
	input  mfrf_pkg::scan_t      scan_in,
	output mfrf_pkg::scan_t      scan_out
);

	localparam logic [CNT_W-1:0]           MY_POS = CNT_W'(CELL_IDX);
	localparam logic [mfrf_pkg::IDX_W-1:0] MY_IDX =
		mfrf_pkg::IDX_W'(CELL_IDX % (1 << mfrf_pkg::IDX_W));

	mfrf_pkg::rule_t rule_q;
	mfrf_pkg::scan_t scan_s1;
	logic            used;
	logic            hit;
	logic            take;

	always_ff @(posedge clk) begin
		if (wr_en && count == MY_POS) begin
			rule_q <= wr_rule;
		end
	end

	assign used = MY_POS < count;

	assign hit = (!rule_q.mask[mfrf_pkg::SEL_PROTO] || rule_q.proto == pkt.proto)
		&& (!rule_q.mask[mfrf_pkg::SEL_SRC]   || rule_q.src == pkt.src)
		&& (!rule_q.mask[mfrf_pkg::SEL_DST]   || rule_q.dst == pkt.dst)
		&& (!rule_q.mask[mfrf_pkg::SEL_SPORT] || rule_q.sport == pkt.sport)
		&& (!rule_q.mask[mfrf_pkg::SEL_DPORT] || (pkt.tcp && rule_q.dport == pkt.dport));

	assign take = scan_in.active && !scan_in.found && used && hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_s1 <= '0;
		end else begin
			scan_s1.active <= scan_in.active;
			scan_s1.found  <= scan_in.found || take;
			if (scan_in.found) begin
				scan_s1.idx <= scan_in.idx;
			end else if (take) begin
				scan_s1.idx <= MY_IDX;
			end else begin
				scan_s1.idx <= '0;
			end
		end
	end

	assign scan_out = scan_s1;

endmodule

### rtl/masked_five_tuple_rule_filter.sv
// ----------------------------------------------------------------------------
// masked_five_tuple_rule_filter
// Ordered five-tuple rule table with first-match blacklist/whitelist verdict.
// ----------------------------------------------------------------------------
// usage
// s_* takes one word per op: s_tuser is the op, s_tdata the packet or rule
// fields. m_* returns one result word per op.
// a classify word is held and broadcast to a chain of RULES cells; a scan
// token walks the chain one cell a cycle and the first hit is carried to the
// end, where it is registered as the result and then moved to the output
// register. add, clear and mode ops skip the scan: their result is registered
// at accept and moves to the output register once that is free.
// one op is in flight at a time: s_tready is high only between ops, and a
// new op is taken while an earlier result still waits on m_tready.
// a stalled m side holds its word; a finished op then waits for the output
// register before s_tready rises again.
// reset empties the table and selects blacklist mode; rule slots hold no
// reset value and only slots below the rule count are ever consulted.
// ----------------------------------------------------------------------------
module masked_five_tuple_rule_filter #(
	parameter int RULES = 128
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// proto_num, src_addr, dst_addr, src_port_num, dst_port_num, field_mask
	input  logic [mfrf_pkg::IN_W-1:0]  s_tdata,
	// op
	input  logic [2:0]                 s_tuser,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// drop, matched, match_index, status, rules_held
	output logic [mfrf_pkg::OUT_W-1:0] m_tdata
);

	localparam int CNT_W = $clog2(RULES + 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(RULES);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_PEND = 3'b100
	} state_t;

	typedef struct packed {
		logic       drop;
		logic       matched;
		logic [6:0] idx;
		logic       status;
		logic [7:0] held;
	} res_t;

	state_t              state_q;
	logic [CNT_W-1:0]    total_q;
	logic [CNT_W-1:0]    total_d;
	logic                white_q;
	logic                white_d;
	logic                start_q;
	logic                out_vld_q;
	logic [mfrf_pkg::OUT_W-1:0] out_q;
	mfrf_pkg::pkt_t      pkt_q;
	mfrf_pkg::rule_t     in_rule;
	res_t                res_q;
	res_t                res_d;
	logic                accept;
	logic                is_add;
	logic                full;
	logic                add_en;
	logic [31:0]         total_ext;
	logic                out_free;
	mfrf_pkg::scan_t     chain [RULES+1];

	assign s_tready = state_q == ST_IDLE;
	assign accept   = s_tvalid && s_tready;

	assign in_rule.proto = s_tdata[7:0];
	assign in_rule.src   = s_tdata[39:8];
	assign in_rule.dst   = s_tdata[71:40];
	assign in_rule.sport = s_tdata[87:72];
	assign in_rule.dport = s_tdata[103:88];
	assign in_rule.mask  = s_tdata[108:104];

	assign is_add = s_tuser == mfrf_pkg::OP_ADD;
	assign full   = total_q == FULL;
	assign add_en = accept && is_add && !full;

	always_comb begin
		total_d = total_q;
		white_d = white_q;
		case (s_tuser)
			mfrf_pkg::OP_ADD: begin
				if (!full) begin
					total_d = total_q + CNT_W'(1);
				end
			end
			mfrf_pkg::OP_CLEAR: begin
				total_d = '0;
			end
			mfrf_pkg::OP_SET_BLACK: begin
				if (white_q) begin
					total_d = '0;
				end
				white_d = 1'b0;
			end
			mfrf_pkg::OP_SET_WHITE: begin
				if (!white_q) begin
					total_d = '0;
				end
				white_d = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign total_ext = 32'(total_d);

	always_comb begin
		res_d         = '0;
		res_d.status  = is_add && full;
		res_d.held    = total_ext[7:0];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pkt_q.proto <= in_rule.proto;
			pkt_q.src   <= in_rule.src;
			pkt_q.dst   <= in_rule.dst;
			pkt_q.dport <= in_rule.dport;
			pkt_q.tcp   <= in_rule.proto == mfrf_pkg::PROTO_TCP;
			if (in_rule.proto == mfrf_pkg::PROTO_TCP || in_rule.proto == mfrf_pkg::PROTO_UDP) begin
				pkt_q.sport <= in_rule.sport;
			end else begin
				pkt_q.sport <= '0;
			end
		end
	end

	assign chain[0].active = start_q;
	assign chain[0].found  = 1'b0;
	assign chain[0].idx    = '0;

	for (genvar k = 0; k < RULES; k++) begin : g_cell
		mfrf_cell #(
			.CELL_IDX (k),
			.CNT_W    (CNT_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.pkt      (pkt_q),
			.wr_en    (add_en),
			.wr_rule  (in_rule),
			.count    (total_q),
			.scan_in  (chain[k]),
			.scan_out (chain[k+1])
		);
	end

	assign out_free = !out_vld_q || m_tready;

	always_ff @(posedge clk) begin
		if (accept && s_tuser != mfrf_pkg::OP_CLASSIFY) begin
			res_q <= res_d;
		end else if (state_q == ST_SCAN && chain[RULES].active) begin
			res_q.drop    <= white_q ? !chain[RULES].found : chain[RULES].found;
			res_q.matched <= chain[RULES].found;
			res_q.idx     <= chain[RULES].idx;
			res_q.status  <= 1'b0;
			res_q.held    <= 8'(32'(total_q));
		end
		if (state_q == ST_PEND && out_free) begin
			out_q <= {6'b0, res_q.held, res_q.status, res_q.idx, res_q.matched, res_q.drop};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			total_q   <= '0;
			white_q   <= 1'b0;
			start_q   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			start_q <= accept && s_tuser == mfrf_pkg::OP_CLASSIFY;
			if (state_q == ST_PEND && out_free) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						total_q <= total_d;
						white_q <= white_d;
						state_q <= (s_tuser == mfrf_pkg::OP_CLASSIFY) ? ST_SCAN : ST_PEND;
					end
				end
				ST_SCAN: begin
					if (chain[RULES].active) begin
						state_q <= ST_PEND;
					end
				end
				ST_PEND: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

endmodule

### rtl/mfrf_checker.sv
// ----------------------------------------------------------------------------
// mfrf_checker
// Port-level checks of the masked five-tuple rule filter, bound to the top.
// ----------------------------------------------------------------------------
module mfrf_checker #(
	parameter int RULES = 128
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [mfrf_pkg::OUT_W-1:0] m_tdata
);

	localparam logic [31:0] FULL_W = 32'(RULES);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result word changed");

	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second word taken while an op is in flight");

	a_no_match_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[1] |-> m_tdata[8:2] == 7'd0)
		else $error("match index set without a match");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[9] |-> m_tdata[17:10] == FULL_W[7:0] && !m_tdata[1])
		else $error("table full flag with wrong rule count");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:18] == 6'd0)
		else $error("result padding bits not zero");

endmodule

bind masked_five_tuple_rule_filter mfrf_checker #(
	.RULES (RULES)
) u_mfrf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### tb/masked_five_tuple_rule_filter_tb.sv
// ----------------------------------------------------------------------------
// masked_five_tuple_rule_filter_tb
// Self-checking bench: ops are streamed in with random gaps and the result
// words are drained with random back-pressure. Each result is compared field
// by field with a behavioural model of the rule table and the verdict.
// The stimulus covers directed corner cases, a full table with refused adds,
// and random rule sets that are probed with matching and near-miss packets.
// ----------------------------------------------------------------------------
module masked_five_tuple_rule_filter_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RULES = 128;
	localparam int STALL_LIMIT = 4000;

	// ops with no defined meaning
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [2:0]      op;
		mfrf_pkg::rule_t f;
	} filter_word_t;

	typedef struct packed {
		logic       drop;
		logic       matched;
		logic [6:0] idx;
		logic       status;
		logic [7:0] held;
	} verdict_t;

	logic                       clk;
	logic                       arst_n;
	logic                       s_tvalid;
	logic                       s_tready;
	logic [mfrf_pkg::IN_W-1:0]  s_tdata;
	logic [2:0]                 s_tuser;
	logic                       m_tvalid;
	logic                       m_tready;
	logic [mfrf_pkg::OUT_W-1:0] m_tdata;

	filter_word_t word_q[$];
	verdict_t     verdict_q[$];
	filter_word_t cur_word;
	bit           word_taken;
	int           s_gap;
	int           m_stall;
	int           idle_cycles;
	int           fail_count;

	// behavioural rule table
	mfrf_pkg::rule_t acl_table[RULES];
	int              acl_count;
	bit              acl_white;

	// stimulus-side view of the table, used only to shape probes
	mfrf_pkg::rule_t gen_rules[$];
	bit              gen_white;

	int           n_classify;
	int           n_match;
	int           n_drop;
	int           n_refused;

	verdict_t     want;
	verdict_t     seen;
	verdict_t     fresh;

	masked_five_tuple_rule_filter #(
		.RULES(RULES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic bit rule_hits(mfrf_pkg::rule_t r, mfrf_pkg::rule_t p);
		if (r.mask[mfrf_pkg::SEL_PROTO] && r.proto != p.proto) return 1'b0;
		if (r.mask[mfrf_pkg::SEL_SRC] && r.src != p.src) return 1'b0;
		if (r.mask[mfrf_pkg::SEL_DST] && r.dst != p.dst) return 1'b0;
		if (r.mask[mfrf_pkg::SEL_SPORT] && r.sport != p.sport) return 1'b0;
		if (r.mask[mfrf_pkg::SEL_DPORT]
				&& (p.proto != mfrf_pkg::PROTO_TCP || r.dport != p.dport)) return 1'b0;
		return 1'b1;
	endfunction

	task automatic judge_word(input filter_word_t w, output verdict_t v);
		mfrf_pkg::rule_t p;
		int              k;
		v = '0;
		p = w.f;
		case (w.op)
		mfrf_pkg::OP_CLASSIFY: begin
			// source port only means something for tcp and udp
			if (p.proto != mfrf_pkg::PROTO_TCP && p.proto != mfrf_pkg::PROTO_UDP) p.sport = '0;
			for (k = 0; k < acl_count && !v.matched; k++) begin
				if (rule_hits(acl_table[k], p)) begin
					v.matched = 1'b1;
					v.idx = k[6:0];
				end
			end
			v.drop = acl_white ? !v.matched : v.matched;
			n_classify++;
			n_match += v.matched;
			n_drop += v.drop;
		end
		mfrf_pkg::OP_ADD: begin
			if (acl_count >= RULES) begin
				v.status = 1'b1;
				n_refused++;
			end else begin
				acl_table[acl_count] = w.f;
				acl_count++;
			end
		end
		mfrf_pkg::OP_CLEAR: acl_count = 0;
		mfrf_pkg::OP_SET_BLACK: begin
			if (acl_white) acl_count = 0;
			acl_white = 1'b0;
		end
		mfrf_pkg::OP_SET_WHITE: begin
			if (!acl_white) acl_count = 0;
			acl_white = 1'b1;
		end
		default: ;
		endcase
		v.held = acl_count[7:0];
	endtask

	task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	function automatic mfrf_pkg::rule_t tuple(logic [7:0] proto, logic [31:0] src,
			logic [31:0] dst, logic [15:0] sport, logic [15:0] dport, logic [4:0] mask);
		mfrf_pkg::rule_t r;
		r.mask = mask;
		r.proto = proto;
		r.src = src;
		r.dst = dst;
		r.sport = sport;
		r.dport = dport;
		return r;
	endfunction

	function automatic mfrf_pkg::rule_t rand_tuple();
		mfrf_pkg::rule_t r;
		case ($urandom_range(0, 3))
		0: r.proto = mfrf_pkg::PROTO_TCP;
		1: r.proto = mfrf_pkg::PROTO_UDP;
		default: r.proto = 8'($urandom_range(0, 255));
		endcase
		r.src = $urandom;
		r.dst = $urandom;
		r.sport = 16'($urandom_range(0, 65535));
		r.dport = 16'($urandom_range(0, 65535));
		r.mask = 5'($urandom_range(0, 31));
		// an empty mask swallows every packet, keep it rare
		if (r.mask == '0 && $urandom_range(0, 7) != 0) r.mask = 5'($urandom_range(1, 31));
		if (r.mask[mfrf_pkg::SEL_DPORT] && $urandom_range(0, 3) != 0)
			r.proto = mfrf_pkg::PROTO_TCP;
		return r;
	endfunction

	// packet built from a rule, unselected fields random or copied, sometimes one bit off
	function automatic mfrf_pkg::rule_t probe_from(mfrf_pkg::rule_t r);
		mfrf_pkg::rule_t p;
		int              b;
		p = rand_tuple();
		if (r.mask[mfrf_pkg::SEL_PROTO] || $urandom_range(0, 1)) p.proto = r.proto;
		if (r.mask[mfrf_pkg::SEL_SRC] || $urandom_range(0, 1)) p.src = r.src;
		if (r.mask[mfrf_pkg::SEL_DST] || $urandom_range(0, 1)) p.dst = r.dst;
		if (r.mask[mfrf_pkg::SEL_SPORT] || $urandom_range(0, 1)) p.sport = r.sport;
		if (r.mask[mfrf_pkg::SEL_DPORT] || $urandom_range(0, 1)) p.dport = r.dport;
		if (r.mask[mfrf_pkg::SEL_DPORT] && !r.mask[mfrf_pkg::SEL_PROTO]
				&& $urandom_range(0, 3) != 0)
			p.proto = mfrf_pkg::PROTO_TCP;
		if ($urandom_range(0, 4) == 0) begin
			b = $urandom_range(0, 15);
			case ($urandom_range(0, 4))
			0: p.proto[b % 8] = !p.proto[b % 8];
			1: p.src[b * 2] = !p.src[b * 2];
			2: p.dst[b * 2 + 1] = !p.dst[b * 2 + 1];
			3: p.sport[b] = !p.sport[b];
			default: p.dport[b] = !p.dport[b];
			endcase
		end
		return p;
	endfunction

	task automatic push_word(logic [2:0] op, mfrf_pkg::rule_t f);
		filter_word_t w;
		w.op = op;
		w.f = f;
		word_q.push_back(w);
		case (op)
		mfrf_pkg::OP_ADD: if (gen_rules.size() < RULES) gen_rules.push_back(f);
		mfrf_pkg::OP_CLEAR: gen_rules.delete();
		mfrf_pkg::OP_SET_BLACK: begin
			if (gen_white) gen_rules.delete();
			gen_white = 1'b0;
		end
		mfrf_pkg::OP_SET_WHITE: begin
			if (!gen_white) gen_rules.delete();
			gen_white = 1'b1;
		end
		default: ;
		endcase
	endtask

	function automatic bit calm();
		return word_q.size() < 60 || (word_q.size() / 40) % 4 == 1;
	endfunction

	// driver: ops change at the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || word_taken) begin
			word_taken = 1'b0;
			if (s_gap > 0) begin
				s_gap--;
				s_tvalid <= 1'b0;
			end else if (word_q.size() > 0) begin
				cur_word = word_q.pop_front();
				s_tdata <= {3'b000, cur_word.f.mask, cur_word.f.dport, cur_word.f.sport,
					cur_word.f.dst, cur_word.f.src, cur_word.f.proto};
				s_tuser <= cur_word.op;
				s_tvalid <= 1'b1;
				if (!calm() && $urandom_range(0, 3) == 0) s_gap = $urandom_range(1, 6);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (m_stall > 0) begin
			m_stall--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (!calm() && $urandom_range(0, 3) == 0) m_stall = $urandom_range(1, 6);
		end
	end

	// monitor: both sides sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				judge_word(cur_word, fresh);
				verdict_q.push_back(fresh);
				word_taken = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				seen = {m_tdata[0], m_tdata[1], m_tdata[8:2], m_tdata[9], m_tdata[17:10]};
				if (verdict_q.size() == 0) begin
					$display("%0t: result word mismatch, expected none actual %h", $time,
						m_tdata);
					fail_count++;
				end else begin
					want = verdict_q.pop_front();
					check_field("drop", want.drop, seen.drop);
					check_field("matched", want.matched, seen.matched);
					check_field("match_index", want.idx, seen.idx);
					check_field("status", want.status, seen.status);
					check_field("rules_held", want.held, seen.held);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles == STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		mfrf_pkg::rule_t r;
		int              k;
		int              pick;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		word_taken = 1'b0;
		s_gap = 0;
		m_stall = 0;
		idle_cycles = 0;
		fail_count = 0;
		acl_count = 0;
		acl_white = 1'b0;
		gen_white = 1'b0;
		n_classify = 0;
		n_match = 0;
		n_drop = 0;
		n_refused = 0;

		// directed corner cases
		push_word(mfrf_pkg::OP_CLASSIFY, '0);
		push_word(OP_SPARE_LO, tuple(8'hFF, '1, '1, '1, '1, 5'h1F));
		push_word(mfrf_pkg::OP_ADD, tuple(mfrf_pkg::PROTO_UDP, 32'h0A000001, 32'h0A000002,
			16'd53, 16'd53, 5'b00001));
		push_word(mfrf_pkg::OP_SET_BLACK, '0);
		push_word(mfrf_pkg::OP_CLASSIFY, tuple(mfrf_pkg::PROTO_UDP, 32'h01020304,
			32'h05060708, 16'd9, 16'd10, '0));
		push_word(mfrf_pkg::OP_ADD, tuple(8'd0, '0, '0, '0, 16'd80, 5'b10000));
		push_word(mfrf_pkg::OP_CLASSIFY, tuple(8'd1, 32'h11111111, 32'h22222222, 16'd7,
			16'd80, '0));
		push_word(mfrf_pkg::OP_CLASSIFY, tuple(mfrf_pkg::PROTO_TCP, 32'h11111111,
			32'h22222222, 16'd7, 16'd80, '0));
		push_word(mfrf_pkg::OP_ADD, tuple(8'd0, '0, '0, 16'd0, '0, 5'b01000));
		push_word(mfrf_pkg::OP_CLASSIFY, tuple(8'd1, 32'h33333333, 32'h44444444, 16'd1234,
			16'd1, '0));
		push_word(mfrf_pkg::OP_CLASSIFY, tuple(mfrf_pkg::PROTO_TCP, 32'h33333333,
			32'h44444444, 16'd1234, 16'd81, '0));
		push_word(mfrf_pkg::OP_ADD, tuple(8'hFF, '1, '1, '1, '1, 5'h1F));
		push_word(mfrf_pkg::OP_CLASSIFY, tuple(8'hFF, '1, '1, '1, '1, 5'h1F));
		push_word(mfrf_pkg::OP_ADD, tuple('0, '0, '0, '0, '0, 5'b00000));
		push_word(mfrf_pkg::OP_CLASSIFY, tuple(mfrf_pkg::PROTO_TCP, 32'h80000000,
			32'h00000001, 16'd5, 16'd5, '0));
		push_word(OP_SPARE_HI, tuple(8'h5A, 32'hA5A5A5A5, 32'h5A5A5A5A, 16'hA5A5, 16'h5A5A,
			5'h15));
		push_word(mfrf_pkg::OP_SET_WHITE, '0);
		push_word(mfrf_pkg::OP_CLASSIFY, tuple(mfrf_pkg::PROTO_TCP, 32'hC0A80001,
			32'hC0A80002, 16'd22, 16'd22, '0));
		push_word(mfrf_pkg::OP_ADD, tuple(mfrf_pkg::PROTO_UDP, 32'hC0A80001, 32'hC0A80002,
			'0, '0, 5'b00110));
		push_word(mfrf_pkg::OP_CLASSIFY, tuple(mfrf_pkg::PROTO_UDP, 32'hC0A80001,
			32'hC0A80002, 16'd99, 16'd98, '0));
		push_word(mfrf_pkg::OP_SET_WHITE, '0);
		push_word(mfrf_pkg::OP_CLEAR, '0);
		push_word(mfrf_pkg::OP_CLASSIFY, tuple(mfrf_pkg::PROTO_UDP, 32'hC0A80001,
			32'hC0A80002, 16'd99, 16'd98, '0));
		push_word(mfrf_pkg::OP_SET_BLACK, '0);

		// fill the table to the last slot, then push past it
		for (k = 0; k < RULES + 2; k++) begin
			r = rand_tuple();
			r.mask = r.mask | 5'b00110;
			if (r.mask[mfrf_pkg::SEL_DPORT]) r.proto = mfrf_pkg::PROTO_TCP;
			push_word(mfrf_pkg::OP_ADD, r);
		end
		push_word(mfrf_pkg::OP_CLASSIFY, gen_rules[RULES - 1]);
		push_word(mfrf_pkg::OP_CLASSIFY, gen_rules[0]);
		push_word(mfrf_pkg::OP_CLASSIFY, probe_from(gen_rules[$urandom_range(0, RULES - 1)]));
		push_word(mfrf_pkg::OP_CLASSIFY, rand_tuple());
		push_word(mfrf_pkg::OP_SET_WHITE, '0);

		// random rule sets with probes
		repeat (290) begin
			pick = $urandom_range(0, 99);
			if (pick < 38 && gen_rules.size() > 0) begin
				push_word(mfrf_pkg::OP_CLASSIFY,
					probe_from(gen_rules[$urandom_range(0, gen_rules.size() - 1)]));
			end else if (pick < 48) begin
				push_word(mfrf_pkg::OP_CLASSIFY, rand_tuple());
			end else if (pick < 78) begin
				push_word(mfrf_pkg::OP_ADD, rand_tuple());
			end else if (pick < 83) begin
				push_word(mfrf_pkg::OP_CLEAR, rand_tuple());
			end else if (pick < 90) begin
				push_word(mfrf_pkg::OP_SET_BLACK, rand_tuple());
			end else if (pick < 97) begin
				push_word(mfrf_pkg::OP_SET_WHITE, rand_tuple());
			end else begin
				push_word(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), rand_tuple());
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (word_q.size() > 0 || s_tvalid || verdict_q.size() > 0) @(posedge clk);
		repeat (RULES + 10) @(posedge clk);

		$display("%0d packets classified: %0d hit a rule, %0d dropped", n_classify, n_match,
			n_drop);
		$display("%0d adds refused on a full table, %0d mismatches", n_refused, fail_count);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/mfrf_pkg.sv
rtl/mfrf_cell.sv
rtl/masked_five_tuple_rule_filter.sv
rtl/mfrf_checker.sv
tb/masked_five_tuple_rule_filter_tb.sv
